@@ rtl/core/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
// Holds the channel payload structs, operation codes and result codes.
// No dependencies.
package ple_pkg;

    localparam int CAPACITY    = 64;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 7;
    localparam int VAL_W       = 32;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_DELETE  = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_DISPLAY = 3'd4
    } t_op;

    localparam logic [1:0] KIND_ENTRY  = 2'd0;
    localparam logic [1:0] KIND_HIT    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_FULL   = 2'd1;
    localparam logic [1:0] STS_BADPOS = 2'd2;
    localparam logic [1:0] STS_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]              mode;
        logic [CNT_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic [1:0]              kind;
        logic [CNT_W-1:0]        entry_position;
        logic signed [VAL_W-1:0] entry_value;
        logic [1:0]              status;
        logic                    last;
    } t_out;

    typedef struct packed {
        t_op                     op;
        logic [CNT_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_cmd;

endpackage

@@ rtl/core/ple_front.sv @@
// Front end of the positional list engine: accepts input transactions,
// decodes the mode and queues commands for the back end. Uses ple_pkg.
module ple_front import ple_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    t_cmd       r_q [0:1];
    logic       r_wr_sel;
    logic       r_rd_sel;
    logic [1:0] r_occ;
    logic [1:0] n_occ;

    logic mode_ok;
    logic accept;
    logic push;
    logic pop;
    t_cmd cmd_new;

    always_comb begin
        unique case (i_in_data.mode)
            OP_APPEND, OP_INSERT, OP_DELETE, OP_SEARCH, OP_DISPLAY: mode_ok = 1'b1;
            default: mode_ok = 1'b0;
        endcase
        cmd_new.op         = t_op'(i_in_data.mode);
        cmd_new.position   = i_in_data.position;
        cmd_new.item_value = i_in_data.item_value;
    end

    assign o_in_ready  = (r_occ != 2'd2);
    assign accept      = i_in_valid && o_in_ready;
    // drop unused modes: they cause no result
    assign push        = accept && mode_ok;
    assign pop         = i_cmd_pop && (r_occ != 2'd0);
    assign o_cmd_valid = (r_occ != 2'd0);
    assign o_cmd       = r_q[r_rd_sel];

    always_comb begin
        n_occ = r_occ;
        if (push && !pop) begin
            n_occ = r_occ + 2'd1;
        end else if (pop && !push) begin
            n_occ = r_occ - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_sel] <= cmd_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_sel <= 1'b0;
            r_rd_sel <= 1'b0;
            r_occ    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_sel <= ~r_wr_sel;
            end
            if (pop) begin
                r_rd_sel <= ~r_rd_sel;
            end
            r_occ <= n_occ;
        end
    end

endmodule

@@ rtl/core/ple_back.sv @@
// Back end of the positional list engine: entry store, shift sequencer,
// list/search scan and a two-entry result buffer. Uses ple_pkg.
module ple_back import ple_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_STATUS = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_PUT    = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FLUSH  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    t_op                     r_op, n_op;
    logic [CNT_W-1:0]        r_pos, n_pos;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [IDX_W-1:0]        r_ptr, n_ptr;
    logic [CNT_W-1:0]        r_left, n_left;
    logic [1:0]              r_status, n_status;
    logic                    r_hold_vld, n_hold_vld;
    t_out                    r_hold, n_hold;

    logic [VAL_W-1:0] r_mem [0:STORE_DEPTH-1];
    logic [VAL_W-1:0] r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    t_out       r_obuf [0:1];
    logic       r_owr_sel;
    logic       r_ord_sel;
    logic [1:0] r_occ;
    logic [1:0] n_occ;

    logic       push;
    t_out       push_data;
    logic       pop;
    logic       space_now;
    logic [2:0] fill;
    logic       scan_room;
    logic       is_full;
    logic       match;
    t_out       scan_res;
    t_out       status_res;
    t_out       hold_last;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;

    assign pop       = (r_occ != 2'd0) && i_out_ready;
    assign space_now = (r_occ != 2'd2) || pop;
    // one result may still come back from the read in flight
    assign fill      = {1'b0, r_occ} + {2'b00, r_rd_vld} - {2'b00, pop};
    assign scan_room = (fill < 3'd2);
    assign is_full   = (r_count >= CNT_W'(CAPACITY));
    assign match     = (r_op != OP_SEARCH) || (r_rd_data == r_val);
    assign count_inc = r_count + 7'd1;
    assign count_dec = r_count - 7'd1;

    always_comb begin
        scan_res.kind           = (r_op == OP_SEARCH) ? KIND_HIT : KIND_ENTRY;
        scan_res.entry_position = {1'b0, r_rd_idx} + 7'd1;
        scan_res.entry_value    = r_rd_data;
        scan_res.status         = STS_OK;
        scan_res.last           = 1'b0;

        status_res.kind           = KIND_STATUS;
        status_res.entry_position = '0;
        status_res.entry_value    = '0;
        status_res.status         = r_status;
        status_res.last           = 1'b1;

        hold_last      = r_hold;
        hold_last.last = 1'b1;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_op       = r_op;
        n_pos      = r_pos;
        n_val      = r_val;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_status   = r_status;
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        mem_we     = 1'b0;
        mem_waddr  = r_count[IDX_W-1:0];
        mem_wdata  = r_val;
        mem_re     = 1'b0;
        mem_raddr  = r_ptr;
        push       = 1'b0;
        push_data  = status_res;
        o_cmd_pop  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_op       = i_cmd.op;
                    n_pos      = i_cmd.position;
                    n_val      = i_cmd.item_value;
                    n_hold_vld = 1'b0;
                    n_ptr      = '0;
                    unique case (i_cmd.op)
                        OP_APPEND: begin
                            if (is_full) begin
                                n_status = STS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = i_cmd.item_value;
                                n_count   = count_inc;
                                n_status  = STS_OK;
                            end
                            n_state = S_STATUS;
                        end
                        OP_INSERT: begin
                            priority if (is_full) begin
                                n_status = STS_FULL;
                                n_state  = S_STATUS;
                            end else if (i_cmd.position == '0 ||
                                         i_cmd.position > count_inc) begin
                                n_status = STS_BADPOS;
                                n_state  = S_STATUS;
                            end else if (i_cmd.position == count_inc) begin
                                // insert at the end: nothing to move
                                mem_we    = 1'b1;
                                mem_wdata = i_cmd.item_value;
                                n_count   = count_inc;
                                n_left    = count_inc;
                                n_status  = STS_OK;
                                n_state   = S_SCAN;
                            end else begin
                                n_ptr    = count_dec[IDX_W-1:0];
                                n_left   = count_inc - i_cmd.position;
                                n_status = STS_OK;
                                n_state  = S_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            priority if (r_count == '0) begin
                                n_status = STS_EMPTY;
                                n_state  = S_STATUS;
                            end else if (i_cmd.position == '0 ||
                                         i_cmd.position > r_count) begin
                                n_status = STS_BADPOS;
                                n_state  = S_STATUS;
                            end else if (i_cmd.position == r_count) begin
                                n_count  = count_dec;
                                n_left   = count_dec;
                                n_status = STS_OK;
                                n_state  = S_SCAN;
                            end else begin
                                n_ptr    = i_cmd.position[IDX_W-1:0];
                                n_left   = r_count - i_cmd.position;
                                n_status = STS_OK;
                                n_state  = S_SHIFT;
                            end
                        end
                        OP_SEARCH, OP_DISPLAY: begin
                            n_left   = r_count;
                            n_status = STS_EMPTY;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_STATUS: begin
                if (space_now) begin
                    push      = 1'b1;
                    push_data = status_res;
                    n_state   = S_IDLE;
                end
            end
            S_SHIFT: begin
                // write back what the previous cycle read, one slot over
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = (r_op == OP_INSERT) ? r_rd_idx + 6'd1 : r_rd_idx - 6'd1;
                    mem_wdata = r_rd_data;
                end
                if (r_left != '0) begin
                    mem_re = 1'b1;
                    n_left = r_left - 7'd1;
                    n_ptr  = (r_op == OP_INSERT) ? r_ptr - 6'd1 : r_ptr + 6'd1;
                end else if (!r_rd_vld) begin
                    if (r_op == OP_INSERT) begin
                        n_state = S_PUT;
                    end else begin
                        n_count = count_dec;
                        n_left  = count_dec;
                        n_ptr   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[IDX_W-1:0] - 6'd1;
                mem_wdata = r_val;
                n_count   = count_inc;
                n_left    = count_inc;
                n_ptr     = '0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                // hold the newest result back until it is known whether it is the last
                if (r_rd_vld && match) begin
                    if (r_hold_vld) begin
                        push      = 1'b1;
                        push_data = r_hold;
                    end
                    n_hold     = scan_res;
                    n_hold_vld = 1'b1;
                end
                if (r_left != '0) begin
                    if (scan_room) begin
                        mem_re = 1'b1;
                        n_ptr  = r_ptr + 6'd1;
                        n_left = r_left - 7'd1;
                    end
                end else if (!r_rd_vld) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (space_now) begin
                    push       = 1'b1;
                    push_data  = r_hold_vld ? hold_last : status_res;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_occ = r_occ;
        if (push && !pop) begin
            n_occ = r_occ + 2'd1;
        end else if (pop && !push) begin
            n_occ = r_occ - 2'd1;
        end
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_obuf[r_owr_sel] <= push_data;
        end
        if (mem_re) begin
            r_rd_idx <= mem_raddr;
        end
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_status <= n_status;
        r_hold   <= n_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_owr_sel  <= 1'b0;
            r_ord_sel  <= 1'b0;
            r_occ      <= 2'd0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_vld   <= mem_re;
            r_hold_vld <= n_hold_vld;
            if (push) begin
                r_owr_sel <= ~r_owr_sel;
            end
            if (pop) begin
                r_ord_sel <= ~r_ord_sel;
            end
            r_occ <= n_occ;
        end
    end

    assign o_out_valid = (r_occ != 2'd0);
    assign o_out_data  = r_obuf[r_ord_sel];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_occ != 2'd2 || pop))
        else $error("result buffer overflow");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_vld && !r_hold_vld))
        else $error("idle with read or held result outstanding");

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("store read and write hit the same entry");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_status_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STATUS && space_now) |=> (r_state == S_IDLE && o_out_valid))
        else $error("status result not delivered");
`endif

endmodule

@@ rtl/core/positional_list_engine.sv @@
// Top level of the positional list engine: front end with command queue
// feeding the store back end. Uses ple_pkg, ple_front and ple_back.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+---------------------
//  input    | i_in_valid   | o_in_ready   | i_in_data  (t_in)
//  output   | o_out_valid  | i_out_ready  | o_out_data (t_out)
//
// Append and every rejected command end in one status result.
// Insert at position p moves the entries from p onward one slot up and then places the
// new one, delete moves the entries after p one slot down, both through the store's single
// read and single write port; the listing that follows, and search and display, then stream
// one result per cycle from the read port while the output is ready.
// Reset clears the entry count and all queues; store contents need no clearing pass.
// A stalled output holds the back end; the front end keeps taking up to two commands.
module positional_list_engine import ple_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    ple_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ple_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
